// ===== rtl/mpba_pkg.sv =====
package mpba_pkg;

  localparam int unsigned NUM_POOLS  = 4;
  localparam int unsigned MAX_BLOCKS = 32;
  localparam int unsigned POOL_W     = $clog2(NUM_POOLS);
  localparam int unsigned BLK_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned MARGIN_W   = 8;
  localparam int unsigned MISS_W     = 16;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;

  localparam int unsigned DEF_POOL0_BLOCKS = 32;
  localparam int unsigned DEF_POOL1_BLOCKS = 16;
  localparam int unsigned DEF_POOL2_BLOCKS = 8;
  localparam int unsigned DEF_POOL3_BLOCKS = 4;

  localparam logic [SIZE_W-1:0]   RST_POOL0_BYTES = 16'd64;
  localparam logic [SIZE_W-1:0]   RST_POOL1_BYTES = 16'd256;
  localparam logic [SIZE_W-1:0]   RST_POOL2_BYTES = 16'd1024;
  localparam logic [SIZE_W-1:0]   RST_POOL3_BYTES = 16'd4096;
  localparam logic [MARGIN_W-1:0] RST_MARGIN      = 8'd16;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_POOL0_BYTES = 3'd0;
  localparam logic [2:0] REG_POOL1_BYTES = 3'd1;
  localparam logic [2:0] REG_POOL2_BYTES = 3'd2;
  localparam logic [2:0] REG_POOL3_BYTES = 3'd3;
  localparam logic [2:0] REG_MARGIN      = 3'd4;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_NONE    = 2'd1,
    ST_FREED   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    logic [NUM_POOLS-1:0][SIZE_W-1:0] pool_bytes;
    logic [MARGIN_W-1:0]              margin;
  } cfg_t;

  typedef struct packed {
    logic             alloc;
    logic             free;
    logic             miss;
    logic [BLK_W-1:0] free_blk;
  } pool_cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0]  top_blk;
    logic              can_free;
    logic [CNT_W-1:0]  in_use;
    logic [CNT_W-1:0]  peak;
    logic [MISS_W-1:0] misses;
  } pool_stat_t;

endpackage

// ===== rtl/multi_pool_block_allocator_unit.sv =====
// four-pool fixed-block allocator
//
// input channel (in_valid_i / in_ready_o): one word per request. op_i selects
// allocate (req_size_i used) or free (free_pool_i / free_block_i used).
// output channel (out_valid_o / out_ready_i): one result word per request,
// in request order: status, pool, block and that pool's statistics after
// the request.
// apb port: pool block sizes at 0x0..0xc, size margin at 0x10; write only
// while the block is idle. pready is tied high, reads return the register.
//
// throughput: one request per cycle while the receiver takes each result.
// all pool updates happen in the single combinational pass between the input
// register and the result register, which hold the request and its result.
// a stalled receiver holds the result register; one more request waits in
// the input register, then in_ready_o drops until the result is taken.
// reset: all pools full (highest index on top), counters zero, registers
// at their default sizes. no clearing pass is needed.
module multi_pool_block_allocator_unit #(
  parameter int unsigned POOL0_BLOCKS = mpba_pkg::DEF_POOL0_BLOCKS,
  parameter int unsigned POOL1_BLOCKS = mpba_pkg::DEF_POOL1_BLOCKS,
  parameter int unsigned POOL2_BLOCKS = mpba_pkg::DEF_POOL2_BLOCKS,
  parameter int unsigned POOL3_BLOCKS = mpba_pkg::DEF_POOL3_BLOCKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [mpba_pkg::SIZE_W-1:0]   req_size_i,
  input  logic [mpba_pkg::POOL_W-1:0]   free_pool_i,
  input  logic [mpba_pkg::BLK_W-1:0]    free_block_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [mpba_pkg::POOL_W-1:0]   pool_index_o,
  output logic [mpba_pkg::BLK_W-1:0]    block_index_o,
  output logic [mpba_pkg::CNT_W-1:0]    pool_in_use_o,
  output logic [mpba_pkg::CNT_W-1:0]    pool_peak_o,
  output logic [mpba_pkg::MISS_W-1:0]   pool_failures_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mpba_pkg::ADDR_W-1:0]   paddr,
  input  logic [mpba_pkg::DATA_W-1:0]   pwdata,
  output logic [mpba_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mpba_pkg::*;

  cfg_t cfg;

  // input register
  logic              in_valid_q;
  op_e               op_q;
  logic [SIZE_W-1:0] req_q;
  logic [POOL_W-1:0] fpool_q;
  logic [BLK_W-1:0]  fblk_q;

  // result register
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [POOL_W-1:0] pool_q, pool_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [CNT_W-1:0]  in_use_q;
  logic [CNT_W-1:0]  peak_q;
  logic [MISS_W-1:0] miss_q;

  pool_cmd_t  [NUM_POOLS-1:0] cmd;
  pool_stat_t [NUM_POOLS-1:0] stat;
  logic       [NUM_POOLS-1:0] avail;

  logic [SIZE_W:0]       sum;
  logic [NUM_POOLS-1:0]  fits;
  logic                  served;
  logic [POOL_W-1:0]     serve_idx;
  logic                  proc;

  // a request is processed once the result register can take its result
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  mpba_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // 17-bit sum so a large request never wraps into a small pool
  assign sum = {1'b0, req_q} + (SIZE_W + 1)'(cfg.margin);

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      fits[p] = (sum <= {1'b0, cfg.pool_bytes[p]});
    end
  end

  // first fitting pool with a free block wins; fitting empty pools before
  // it (or all of them when none serves) count a miss
  always_comb begin
    served    = 1'b0;
    serve_idx = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      cmd[p].alloc    = 1'b0;
      cmd[p].free     = proc && (op_q == OP_FREE) && (fpool_q == POOL_W'(p));
      cmd[p].miss     = 1'b0;
      cmd[p].free_blk = fblk_q;
      if ((op_q == OP_ALLOC) && fits[p] && !served) begin
        if (avail[p]) begin
          served        = 1'b1;
          serve_idx     = POOL_W'(p);
          cmd[p].alloc  = proc;
        end else begin
          cmd[p].miss   = proc;
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_POOLS; g++) begin : g_pool
    localparam int unsigned NB = (g == 0) ? POOL0_BLOCKS :
                                 (g == 1) ? POOL1_BLOCKS :
                                 (g == 2) ? POOL2_BLOCKS : POOL3_BLOCKS;
    mpba_pool #(
      .NBLK (NB)
    ) u_pool (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd[g]),
      .avail_o (avail[g]),
      .stat_o  (stat[g])
    );
  end

  always_comb begin
    if (op_q == OP_ALLOC) begin
      if (served) begin
        status_d = ST_ALLOC;
        pool_d   = serve_idx;
        blk_d    = stat[serve_idx].top_blk;
      end else begin
        status_d = ST_NONE;
        pool_d   = '0;
        blk_d    = '0;
      end
    end else begin
      status_d = stat[fpool_q].can_free ? ST_FREED : ST_INVALID;
      pool_d   = fpool_q;
      blk_d    = fblk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q    <= op_e'(op_i);
      req_q   <= req_size_i;
      fpool_q <= free_pool_i;
      fblk_q  <= free_block_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // statistics are the post-update values of the reported pool
  always_ff @(posedge clk_i) begin
    if (proc) begin
      status_q <= status_d;
      pool_q   <= pool_d;
      blk_q    <= blk_d;
      in_use_q <= stat[pool_d].in_use;
      peak_q   <= stat[pool_d].peak;
      miss_q   <= stat[pool_d].misses;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign pool_index_o    = pool_q;
  assign block_index_o   = blk_q;
  assign pool_in_use_o   = in_use_q;
  assign pool_peak_o     = peak_q;
  assign pool_failures_o = miss_q;

endmodule

// ===== rtl/mpba_cfg.sv =====
module mpba_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpba_pkg::ADDR_W-1:0] paddr,
  input  logic [mpba_pkg::DATA_W-1:0] pwdata,
  output logic [mpba_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mpba_pkg::cfg_t              cfg_o
);
  import mpba_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_POOL0_BYTES: cfg_d.pool_bytes[0] = pwdata[SIZE_W-1:0];
        REG_POOL1_BYTES: cfg_d.pool_bytes[1] = pwdata[SIZE_W-1:0];
        REG_POOL2_BYTES: cfg_d.pool_bytes[2] = pwdata[SIZE_W-1:0];
        REG_POOL3_BYTES: cfg_d.pool_bytes[3] = pwdata[SIZE_W-1:0];
        REG_MARGIN:      cfg_d.margin        = pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POOL0_BYTES: prdata = DATA_W'(cfg_q.pool_bytes[0]);
      REG_POOL1_BYTES: prdata = DATA_W'(cfg_q.pool_bytes[1]);
      REG_POOL2_BYTES: prdata = DATA_W'(cfg_q.pool_bytes[2]);
      REG_POOL3_BYTES: prdata = DATA_W'(cfg_q.pool_bytes[3]);
      REG_MARGIN:      prdata = DATA_W'(cfg_q.margin);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_bytes[0] <= RST_POOL0_BYTES;
      cfg_q.pool_bytes[1] <= RST_POOL1_BYTES;
      cfg_q.pool_bytes[2] <= RST_POOL2_BYTES;
      cfg_q.pool_bytes[3] <= RST_POOL3_BYTES;
      cfg_q.margin        <= RST_MARGIN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/mpba_pool.sv =====
module mpba_pool #(
  parameter int unsigned NBLK = mpba_pkg::MAX_BLOCKS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpba_pkg::pool_cmd_t  cmd_i,
  output logic                 avail_o,
  output mpba_pkg::pool_stat_t stat_o
);
  import mpba_pkg::*;

  localparam int unsigned       IW     = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam logic [CNT_W-1:0]  NBLK_C = CNT_W'(NBLK);

  logic [BLK_W-1:0]  stack_q [NBLK];
  logic [NBLK-1:0]   map_q;
  logic [CNT_W-1:0]  top_q, top_d;
  logic [CNT_W-1:0]  in_use_q, in_use_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic [MISS_W-1:0] miss_q, miss_d;
  logic [CNT_W-1:0]  top_m1;
  logic [CNT_W-1:0]  in_use_p1;
  logic [IW-1:0]     fidx;
  logic              can_free;
  logic              do_alloc;
  logic              do_free;

  assign top_m1    = top_q - 1'b1;
  assign in_use_p1 = in_use_q + 1'b1;
  assign fidx      = cmd_i.free_blk[IW-1:0];
  assign can_free  = (CNT_W'(cmd_i.free_blk) < NBLK_C) && map_q[fidx] && (top_q < NBLK_C);
  assign do_alloc  = cmd_i.alloc && (top_q != '0);
  assign do_free   = cmd_i.free && can_free;

  always_comb begin
    top_d    = top_q;
    in_use_d = in_use_q;
    peak_d   = peak_q;
    miss_d   = miss_q;
    if (do_alloc) begin
      top_d    = top_m1;
      in_use_d = in_use_p1;
      if (in_use_p1 > peak_q) begin
        peak_d = in_use_p1;
      end
    end else if (do_free) begin
      top_d = top_q + 1'b1;
      if (in_use_q != '0) begin
        in_use_d = in_use_q - 1'b1;
      end
    end
    if (cmd_i.miss && (miss_q != '1)) begin
      miss_d = miss_q + 1'b1;
    end
  end

  // avail_o and top_blk depend on stored state only; the rest follow cmd_i
  assign avail_o          = (top_q != '0);
  assign stat_o.top_blk   = stack_q[top_m1[IW-1:0]];
  assign stat_o.can_free  = can_free;
  assign stat_o.in_use    = in_use_d;
  assign stat_o.peak      = peak_d;
  assign stat_o.misses    = miss_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q    <= NBLK_C;
      in_use_q <= '0;
      peak_q   <= '0;
      miss_q   <= '0;
      map_q    <= '0;
      for (int i = 0; i < NBLK; i++) begin
        stack_q[i] <= BLK_W'(i);
      end
    end else begin
      top_q    <= top_d;
      in_use_q <= in_use_d;
      peak_q   <= peak_d;
      miss_q   <= miss_d;
      if (do_alloc) begin
        map_q[stat_o.top_blk[IW-1:0]] <= 1'b1;
      end
      if (do_free) begin
        map_q[fidx]                <= 1'b0;
        stack_q[top_q[IW-1:0]]     <= cmd_i.free_blk;
      end
    end
  end

  // every block is either on the free stack or marked in use
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q + in_use_q) == NBLK_C)
    else $error("pool block count not conserved");

  a_map_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(map_q)) == in_use_q)
    else $error("in-use bitmap disagrees with in-use count");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= in_use_q)
    else $error("peak below in-use count");

endmodule

// ===== test/multi_pool_block_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module multi_pool_block_allocator_unit_tb;
  import mpba_pkg::*;

  localparam int unsigned BLOCKS0 = DEF_POOL0_BLOCKS;
  localparam int unsigned BLOCKS1 = DEF_POOL1_BLOCKS;
  localparam int unsigned BLOCKS2 = DEF_POOL2_BLOCKS;
  localparam int unsigned BLOCKS3 = DEF_POOL3_BLOCKS;
  localparam int unsigned WORDS_PER_PHASE = 270;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SHOWN_LIMIT     = 10;

  // one request word
  typedef struct packed {
    op_e               op;
    logic [SIZE_W-1:0] size;
    logic [POOL_W-1:0] fpool;
    logic [BLK_W-1:0]  fblk;
  } req_word_t;

  // one result word
  typedef struct packed {
    status_e           status;
    logic [POOL_W-1:0] pool;
    logic [BLK_W-1:0]  blk;
    logic [CNT_W-1:0]  in_use;
    logic [CNT_W-1:0]  peak;
    logic [MISS_W-1:0] misses;
  } pool_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  // directed stimulus row: a request word or a register write
  typedef struct {
    row_kind_e    kind;
    req_word_t    word;
    logic [2:0]   reg_idx;
    logic [15:0]  reg_val;
    bit           fixed;
    pool_result_t res;
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block signals
  // ---------------------------------------------------------------------------
  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic                 op_i         = OP_ALLOC;
  logic [SIZE_W-1:0]    req_size_i   = '0;
  logic [POOL_W-1:0]    free_pool_i  = '0;
  logic [BLK_W-1:0]     free_block_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [1:0]           status_o;
  logic [POOL_W-1:0]    pool_index_o;
  logic [BLK_W-1:0]     block_index_o;
  logic [CNT_W-1:0]     pool_in_use_o;
  logic [CNT_W-1:0]     pool_peak_o;
  logic [MISS_W-1:0]    pool_failures_o;
  logic                 psel         = 1'b0;
  logic                 penable      = 1'b0;
  logic                 pwrite       = 1'b0;
  logic [ADDR_W-1:0]    paddr        = '0;
  logic [DATA_W-1:0]    pwdata       = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  multi_pool_block_allocator_unit #(
    .POOL0_BLOCKS(BLOCKS0),
    .POOL1_BLOCKS(BLOCKS1),
    .POOL2_BLOCKS(BLOCKS2),
    .POOL3_BLOCKS(BLOCKS3)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .req_size_i     (req_size_i),
    .free_pool_i    (free_pool_i),
    .free_block_i   (free_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .pool_index_o   (pool_index_o),
    .block_index_o  (block_index_o),
    .pool_in_use_o  (pool_in_use_o),
    .pool_peak_o    (pool_peak_o),
    .pool_failures_o(pool_failures_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // allocator shadow: free stacks, in-use bits, counters and register copies
  // ---------------------------------------------------------------------------
  logic [BLK_W-1:0]    free_stack [NUM_POOLS][MAX_BLOCKS];
  logic [CNT_W-1:0]    stack_top  [NUM_POOLS];
  bit                  in_use_map [NUM_POOLS][MAX_BLOCKS];
  logic [CNT_W-1:0]    use_cnt    [NUM_POOLS];
  logic [CNT_W-1:0]    peak_cnt   [NUM_POOLS];
  logic [MISS_W-1:0]   miss_cnt   [NUM_POOLS];
  logic [SIZE_W-1:0]   pool_bytes [NUM_POOLS];
  logic [MARGIN_W-1:0] margin;

  pool_result_t pending_results [$];
  stim_row_t    stim_rows [$];
  int unsigned  bad_words;
  int unsigned  cycle_cnt;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  logic         stall_hold;

  // block count of a pool, capped at the stack depth
  function automatic int unsigned blocks_in(input logic [POOL_W-1:0] p);
    int unsigned n;
    case (p)
      2'd0:    n = BLOCKS0;
      2'd1:    n = BLOCKS1;
      2'd2:    n = BLOCKS2;
      default: n = BLOCKS3;
    endcase
    return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
  endfunction

  function automatic void reset_pools();
    for (int p = 0; p < NUM_POOLS; p++) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        free_stack[p][i] = BLK_W'(i);
        in_use_map[p][i] = 1'b0;
      end
      stack_top[p] = CNT_W'(blocks_in(POOL_W'(p)));
      use_cnt[p]   = '0;
      peak_cnt[p]  = '0;
      miss_cnt[p]  = '0;
    end
    pool_bytes[0] = RST_POOL0_BYTES;
    pool_bytes[1] = RST_POOL1_BYTES;
    pool_bytes[2] = RST_POOL2_BYTES;
    pool_bytes[3] = RST_POOL3_BYTES;
    margin        = RST_MARGIN;
  endfunction

  // applies one request to the shadow pools, returns the result word it causes
  function automatic pool_result_t apply_pool_word(input req_word_t w);
    pool_result_t     r;
    logic [SIZE_W:0]  need;
    logic [BLK_W-1:0] b;
    bit               served;
    r      = '0;
    served = 1'b0;
    if (w.op == OP_ALLOC) begin
      // 17-bit sum, so a request near the top of the range fits no pool
      need     = {1'b0, w.size} + (SIZE_W+1)'(margin);
      r.status = ST_NONE;
      for (int p = 0; p < NUM_POOLS; p++) begin
        if (!served && need <= {1'b0, pool_bytes[p]}) begin
          if (stack_top[p] != 0) begin
            stack_top[p]--;
            b = free_stack[p][stack_top[p]];
            in_use_map[p][b] = 1'b1;
            use_cnt[p]++;
            if (use_cnt[p] > peak_cnt[p]) peak_cnt[p] = use_cnt[p];
            r.status = ST_ALLOC;
            r.pool   = POOL_W'(p);
            r.blk    = b;
            served   = 1'b1;
          end else if (miss_cnt[p] != '1) begin
            // pool fits but is empty: saturating miss count
            miss_cnt[p]++;
          end
        end
      end
    end else begin
      r.pool = w.fpool;
      r.blk  = w.fblk;
      if (w.fblk < blocks_in(w.fpool) && in_use_map[w.fpool][w.fblk]) begin
        in_use_map[w.fpool][w.fblk] = 1'b0;
        free_stack[w.fpool][stack_top[w.fpool]] = w.fblk;
        stack_top[w.fpool]++;
        if (use_cnt[w.fpool] != 0) use_cnt[w.fpool]--;
        r.status = ST_FREED;
      end else begin
        // out of range, double free or wrong pool: nothing changes
        r.status = ST_INVALID;
      end
    end
    r.in_use = use_cnt[r.pool];
    r.peak   = peak_cnt[r.pool];
    r.misses = miss_cnt[r.pool];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random request words
  // ---------------------------------------------------------------------------
  function automatic req_word_t pick_word();
    req_word_t   w;
    int unsigned kind;
    int unsigned sel;
    int          top;
    int unsigned p;
    int unsigned p0;
    int unsigned b;
    int unsigned b0;
    bit          found;
    w.size  = SIZE_W'($urandom);
    w.fpool = POOL_W'($urandom_range(0, 3));
    w.fblk  = BLK_W'($urandom_range(0, 31));
    kind    = $urandom_range(0, 99);
    found   = 1'b0;
    if (kind < 48) begin
      w.op = OP_ALLOC;
      sel  = $urandom_range(0, 99);
      if (sel < 70) begin
        // aim at the size boundary of one pool
        p   = $urandom_range(0, 3);
        top = int'(pool_bytes[p]) - int'(margin);
        if (top < 0) top = 0;
        top = top - int'($urandom_range(0, (top < 32) ? top : 32));
        if ($urandom_range(0, 4) == 0 && top < 65535) top++;
        w.size = SIZE_W'(top);
      end else if (sel < 80) begin
        w.size = SIZE_W'($urandom_range(0, 16));
      end else if (sel < 85) begin
        w.size = SIZE_W'(65535 - $urandom_range(0, 300));
      end
    end else begin
      w.op = OP_FREE;
      if (kind < 82) begin
        // legal free of some block that is in use now
        p0 = $urandom_range(0, 3);
        for (int k = 0; k < NUM_POOLS; k++) begin
          p = (p0 + k) % NUM_POOLS;
          if (!found && use_cnt[p] != 0) begin
            b0 = $urandom_range(0, 31);
            for (int j = 0; j < MAX_BLOCKS; j++) begin
              b = (b0 + j) % MAX_BLOCKS;
              if (!found && in_use_map[p][b]) begin
                w.fpool = POOL_W'(p);
                w.fblk  = BLK_W'(b);
                found   = 1'b1;
              end
            end
          end
        end
      end
      // otherwise the random pool and block stand: mostly invalid frees
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // offers one word, holds it until taken, then queues what it must produce
  task automatic send_word(input req_word_t w, input bit fixed, input pool_result_t res);
    pool_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= w.op;
    req_size_i   <= w.size;
    free_pool_i  <= w.fpool;
    free_block_i <= w.fblk;
    do @(posedge clk_i); while (!in_ready_o);
    pred = apply_pool_word(w);
    pending_results.push_back(fixed ? res : pred);
  endtask

  // block is idle once every result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // apb write: setup phase, then access until pready
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POOL0_BYTES: pool_bytes[0] = val;
      REG_POOL1_BYTES: pool_bytes[1] = val;
      REG_POOL2_BYTES: pool_bytes[2] = val;
      REG_POOL3_BYTES: pool_bytes[3] = val;
      REG_MARGIN:      margin = val[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [15:0] b0, input logic [15:0] b1,
                           input logic [15:0] b2, input logic [15:0] b3,
                           input logic [15:0] m);
    wait_drained();
    write_reg(REG_POOL0_BYTES, b0);
    write_reg(REG_POOL1_BYTES, b1);
    write_reg(REG_POOL2_BYTES, b2);
    write_reg(REG_POOL3_BYTES, b3);
    write_reg(REG_MARGIN, m);
  endtask

  task automatic send_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_word(pick_word(), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_word(input op_e op, input int unsigned size,
                                   input int unsigned fp, input int unsigned fb);
    stim_row_t r;
    r.kind    = ROW_WORD;
    r.word    = {op, SIZE_W'(size), POOL_W'(fp), BLK_W'(fb)};
    r.reg_idx = '0;
    r.reg_val = '0;
    r.fixed   = 1'b0;
    r.res     = '0;
    stim_rows.push_back(r);
  endfunction

  // row whose result is plain from the pool state
  function automatic void add_known(input op_e op, input int unsigned size,
                                    input int unsigned fp, input int unsigned fb,
                                    input status_e st, input int unsigned pool,
                                    input int unsigned blk, input int unsigned iu,
                                    input int unsigned pk, input int unsigned ms);
    add_word(op, size, fp, fb);
    stim_rows[$].fixed = 1'b1;
    stim_rows[$].res   = {st, POOL_W'(pool), BLK_W'(blk), CNT_W'(iu), CNT_W'(pk),
                          MISS_W'(ms)};
  endfunction

  function automatic void add_reg(input logic [2:0] idx, input int unsigned val);
    stim_row_t r;
    r.kind    = ROW_REG;
    r.word    = '0;
    r.reg_idx = idx;
    r.reg_val = 16'(val);
    r.fixed   = 1'b0;
    r.res     = '0;
    stim_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random back-pressure plus one long hold in phase three
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= !stall_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic flag_word(input string why, input pool_result_t want,
                           input pool_result_t got);
    if (bad_words < SHOWN_LIMIT) begin
      $display("%s: want st=%0d pool=%0d blk=%0d use=%0d peak=%0d miss=%0d",
               why, want.status, want.pool, want.blk, want.in_use, want.peak,
               want.misses);
      $display("  got st=%0d pool=%0d blk=%0d use=%0d peak=%0d miss=%0d",
               got.status, got.pool, got.blk, got.in_use, got.peak, got.misses);
    end
    bad_words++;
  endtask

  // compare each result word with the oldest pending one
  always @(posedge clk_i) begin : check_results
    pool_result_t got;
    pool_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o);
      got.pool   = pool_index_o;
      got.blk    = block_index_o;
      got.in_use = pool_in_use_o;
      got.peak   = pool_peak_o;
      got.misses = pool_failures_o;
      if (pending_results.size() == 0) begin
        flag_word("result word with none pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.pool !== want.pool ||
            got.blk !== want.blk || got.in_use !== want.in_use ||
            got.peak !== want.peak || got.misses !== want.misses) begin
          flag_word("result word mismatch", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bad_words     = 0;
    cycle_cnt     = 0;
    send_idle_pct = 18;
    recv_idle_pct = 45;
    stall_hold    = 1'b0;
    reset_pools();

    // after reset: invalid free, boundary fits, no-fit, double and wrong-pool frees
    add_known(OP_FREE,      0, 0,  0, ST_INVALID, 0,  0, 0, 0, 0);
    add_known(OP_ALLOC,     0, 0,  0, ST_ALLOC,   0, 31, 1, 1, 0);
    add_known(OP_ALLOC,    48, 0,  0, ST_ALLOC,   0, 30, 2, 2, 0);
    add_known(OP_ALLOC,    49, 0,  0, ST_ALLOC,   1, 15, 1, 1, 0);
    add_known(OP_ALLOC, 65535, 3, 31, ST_NONE,    0,  0, 2, 2, 0);
    add_known(OP_FREE,      0, 0, 31, ST_FREED,   0, 31, 1, 2, 0);
    add_known(OP_FREE,      0, 0, 31, ST_INVALID, 0, 31, 1, 2, 0);
    add_known(OP_FREE,      0, 1, 30, ST_INVALID, 1, 30, 1, 1, 0);
    add_known(OP_FREE,      0, 3, 31, ST_INVALID, 3, 31, 0, 0, 0);
    add_known(OP_FREE,  65535, 2,  0, ST_INVALID, 2,  0, 0, 0, 0);
    add_known(OP_ALLOC,  4080, 3, 31, ST_ALLOC,   3,  3, 1, 1, 0);
    // drain the largest pool, then miss on it
    add_word(OP_ALLOC, 4000, 0, 0);
    add_word(OP_ALLOC, 4000, 0, 0);
    add_word(OP_ALLOC, 4000, 0, 0);
    add_word(OP_ALLOC, 4000, 0, 0);
    add_word(OP_ALLOC, 1000, 0, 0);
    add_word(OP_FREE,     0, 3, 0);
    // widest margin with a zero-size pool in front
    add_reg(REG_MARGIN, 255);
    add_reg(REG_POOL0_BYTES, 0);
    add_reg(REG_POOL1_BYTES, 65535);
    add_word(OP_ALLOC, 0, 0, 0);
    // zero margin: only a zero request fits the zero-size pool
    add_reg(REG_MARGIN, 0);
    add_word(OP_ALLOC,     0, 0, 0);
    add_word(OP_ALLOC, 65535, 0, 0);
    add_reg(REG_POOL1_BYTES, 1);
    add_reg(REG_POOL2_BYTES, 1);
    add_reg(REG_POOL3_BYTES, 65535);
    add_word(OP_ALLOC, 1, 0, 0);
    add_word(OP_ALLOC, 2, 0, 0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        send_word(stim_rows[i].word, stim_rows[i].fixed, stim_rows[i].res);
      end
    end

    // phase one: ordinary ascending sizes, sender idles little, receiver a lot
    set_sizes(16'($urandom_range(16, 200)), 16'($urandom_range(201, 1200)),
              16'($urandom_range(1201, 8000)), 16'($urandom_range(8001, 40000)),
              16'($urandom_range(0, 64)));
    send_random(WORDS_PER_PHASE);

    // phase two: extreme sizes and margin, idling swapped
    set_sizes(16'd1, 16'($urandom_range(256, 2000)), 16'd65535, 16'd65535, 16'd255);
    send_idle_pct <= 45;
    recv_idle_pct <= 18;
    send_random(WORDS_PER_PHASE);

    // phase three: reset sizes, no idling, one long receiver hold so the block backs up
    set_sizes(RST_POOL0_BYTES, RST_POOL1_BYTES, RST_POOL2_BYTES, RST_POOL3_BYTES,
              16'(RST_MARGIN));
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    fork
      send_random(WORDS_PER_PHASE);
      begin
        repeat (30) @(posedge clk_i);
        stall_hold <= 1'b1;
        repeat (300) @(posedge clk_i);
        stall_hold <= 1'b0;
      end
    join

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (bad_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== multi_pool_block_allocator_unit.f =====
rtl/mpba_pkg.sv
rtl/mpba_cfg.sv
rtl/mpba_pool.sv
rtl/multi_pool_block_allocator_unit.sv
test/multi_pool_block_allocator_unit_tb.sv
